>>> design/hssp_pkg.sv
`default_nettype none

package hssp_pkg;

    localparam int POSITION_MAX = 4096;
    localparam int POS_W        = 12;
    localparam int WRAP_W       = 13;
    localparam int DIV_STAGES   = POS_W;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_MOVE    = 2'd1;
    localparam logic [1:0] KIND_HOME    = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
    localparam logic [1:0] REG_REVERSE       = 2'd1;
    localparam logic [1:0] REG_HOME_EXTRA    = 2'd2;

    localparam logic [3:0] PHASE_PATTERN [0:7] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    // one item on its way through the target remainder stages
    typedef struct packed {
        logic [3:0]       coils;
        logic [POS_W-1:0] position;
        logic             busy;
        logic             rejected;
        logic [POS_W-1:0] pos_mod;
        logic [POS_W-1:0] target;
        logic [POS_W-1:0] rem;
    } pipe_t;

endpackage

`default_nettype wire

>>> design/half_step_stepper_positioner.sv
// Half-step stepper positioner. Takes one item per clock on the s_ side (kind in
// s_tuser: tick, move, home, release) and returns one result item per input on the
// m_ side. The step state is updated at the accepting edge, the target is then
// reduced modulo the wrap count by twelve restoring remainder stages (one bit each)
// and the distance is formed in the output register. A new item is taken every
// cycle while s_tready is high; an empty stage accepts even while a later one
// holds, so up to 13 items are in flight before s_tready drops under m_tready
// backpressure. A write to the steps per revolution register starts a reduction
// of the stored position by a bit-serial remainder unit; s_tready is low while
// it runs. Registers sit at byte addresses 0 (steps per revolution), 4 (reverse)
// and 8 (extra homing steps).
`default_nettype none

module half_step_stepper_positioner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // target_step[11:0], hall_active[12]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // coils[3:0], position[15:4], busy_res[16], distance[28:17], rejected[29]
    output logic [31:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NS = hssp_pkg::DIV_STAGES;
    localparam int PW = hssp_pkg::POS_W;
    localparam int WW = hssp_pkg::WRAP_W;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_MOVE,
        MODE_SEARCH,
        MODE_OFFSET
    } mode_t;

    // configuration
    logic [WW-1:0] steps_rev_reg;
    logic          reverse_reg;
    logic [PW-1:0] home_extra_reg;
    logic [WW-1:0] wrap;
    logic [WW-1:0] wrap_m1;
    logic          cfg_wr;

    // position reduction after a wrap count change
    logic          recalc_reg;
    logic [3:0]    rcnt_reg;
    logic [PW-1:0] rrem_reg;
    logic [WW-1:0] rshift;
    logic [PW-1:0] rrem_next;

    // step state
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] posmod_reg, posmod_next;
    logic [2:0]    phase_reg, phase_next;
    logic          prev_hall_reg, prev_hall_next;
    mode_t         mode_reg, mode_next;
    logic [PW-1:0] tgt_reg, tgt_next;
    logic [PW-1:0] ofs_reg, ofs_next;
    logic [3:0]    coil_reg, coil_next;

    logic [1:0]    in_kind;
    logic [PW-1:0] in_target;
    logic          in_hall;
    logic          s_acc;
    logic          rejected;
    logic [PW-1:0] ofs_dec;

    logic [PW-1:0] p_fwd, p_bwd;
    logic [PW-1:0] step_pos;
    logic [2:0]    step_phase;

    // remainder pipeline
    hssp_pkg::pipe_t pipe_in  [NS];
    hssp_pkg::pipe_t pipe_reg [NS];
    logic [NS-1:0]   v_reg;
    logic [NS-1:0]   vin;
    logic [NS:0]     take;

    logic          o_valid_reg;
    logic [31:0]   o_data_reg;
    logic [WW-1:0] diff;
    logic [PW-1:0] fwd_dist;

    assign in_kind   = s_tuser;
    assign in_target = s_tdata[11:0];
    assign in_hall   = s_tdata[12];

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        if (steps_rev_reg == '0) begin
            wrap = WW'(1);
        end else if (steps_rev_reg > WW'(hssp_pkg::POSITION_MAX)) begin
            wrap = WW'(hssp_pkg::POSITION_MAX);
        end else begin
            wrap = steps_rev_reg;
        end
        wrap_m1 = wrap - WW'(1);
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            hssp_pkg::REG_STEPS_PER_REV: prdata = 32'(steps_rev_reg);
            hssp_pkg::REG_REVERSE:       prdata = 32'(reverse_reg);
            hssp_pkg::REG_HOME_EXTRA:    prdata = 32'(home_extra_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        rshift = {rrem_reg, pos_reg[rcnt_reg]};
        if (rshift >= wrap) begin
            rrem_next = PW'(rshift - wrap);
        end else begin
            rrem_next = rshift[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_rev_reg  <= WW'(hssp_pkg::POSITION_MAX);
            reverse_reg    <= 1'b0;
            home_extra_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                hssp_pkg::REG_STEPS_PER_REV: steps_rev_reg  <= pwdata[WW-1:0];
                hssp_pkg::REG_REVERSE:       reverse_reg    <= pwdata[0];
                hssp_pkg::REG_HOME_EXTRA:    home_extra_reg <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // step datapath
    always_comb begin
        p_fwd = ({1'b0, posmod_reg} == wrap_m1) ? '0 : posmod_reg + PW'(1);
        p_bwd = (posmod_reg == '0) ? wrap_m1[PW-1:0] : posmod_reg - PW'(1);
        step_pos   = reverse_reg ? p_bwd : p_fwd;
        step_phase = reverse_reg ? phase_reg + 3'd1 : phase_reg - 3'd1;
        ofs_dec    = ofs_reg - PW'(1);
    end

    always_comb begin
        pos_next       = pos_reg;
        posmod_next    = posmod_reg;
        phase_next     = phase_reg;
        prev_hall_next = prev_hall_reg;
        mode_next      = mode_reg;
        tgt_next       = tgt_reg;
        ofs_next       = ofs_reg;
        coil_next      = coil_reg;
        rejected       = 1'b0;
        unique case (in_kind)
            hssp_pkg::KIND_MOVE: begin
                if ({1'b0, in_target} >= wrap) begin
                    rejected = 1'b1;
                end else begin
                    tgt_next  = in_target;
                    mode_next = (posmod_reg == in_target) ? MODE_IDLE : MODE_MOVE;
                end
            end
            hssp_pkg::KIND_HOME: begin
                mode_next = MODE_SEARCH;
                ofs_next  = '0;
            end
            hssp_pkg::KIND_RELEASE: begin
                coil_next = '0;
                mode_next = MODE_IDLE;
            end
            default: begin
                unique case (mode_reg)
                    MODE_MOVE: begin
                        if ({1'b0, tgt_reg} >= wrap) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            coil_next      = hssp_pkg::PHASE_PATTERN[phase_reg];
                            phase_next     = step_phase;
                            prev_hall_next = in_hall;
                            pos_next       = (in_hall && !prev_hall_reg) ? '0 : step_pos;
                            if (pos_next == tgt_reg) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                    MODE_SEARCH: begin
                        if (in_hall) begin
                            if (home_extra_reg == '0) begin
                                pos_next  = '0;
                                mode_next = MODE_IDLE;
                            end else begin
                                ofs_next  = home_extra_reg;
                                mode_next = MODE_OFFSET;
                            end
                        end else begin
                            coil_next      = hssp_pkg::PHASE_PATTERN[phase_reg];
                            phase_next     = step_phase;
                            prev_hall_next = 1'b0;
                            pos_next       = step_pos;
                        end
                    end
                    MODE_OFFSET: begin
                        coil_next      = hssp_pkg::PHASE_PATTERN[phase_reg];
                        phase_next     = step_phase;
                        prev_hall_next = in_hall;
                        pos_next       = (in_hall && !prev_hall_reg) ? '0 : step_pos;
                        ofs_next       = ofs_dec;
                        if (ofs_dec == '0) begin
                            pos_next  = '0;
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
        if (pos_next != pos_reg) begin
            posmod_next = pos_next;
        end
    end

    assign s_tready = take[0] & !recalc_reg;
    assign s_acc    = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            posmod_reg    <= '0;
            phase_reg     <= 3'd7;
            prev_hall_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            tgt_reg       <= '0;
            ofs_reg       <= '0;
            coil_reg      <= '0;
            recalc_reg    <= 1'b0;
            rcnt_reg      <= '0;
            rrem_reg      <= '0;
        end else begin
            if (s_acc) begin
                pos_reg       <= pos_next;
                posmod_reg    <= posmod_next;
                phase_reg     <= phase_next;
                prev_hall_reg <= prev_hall_next;
                mode_reg      <= mode_next;
                tgt_reg       <= tgt_next;
                ofs_reg       <= ofs_next;
                coil_reg      <= coil_next;
            end
            if (cfg_wr && paddr[3:2] == hssp_pkg::REG_STEPS_PER_REV) begin
                recalc_reg <= 1'b1;
                rcnt_reg   <= 4'(PW - 1);
                rrem_reg   <= '0;
            end else if (recalc_reg) begin
                rrem_reg <= rrem_next;
                rcnt_reg <= rcnt_reg - 4'd1;
                if (rcnt_reg == '0) begin
                    posmod_reg <= rrem_next;
                    recalc_reg <= 1'b0;
                end
            end
        end
    end

    // target remainder stages
    always_comb begin
        pipe_in[0].coils    = coil_next;
        pipe_in[0].position = pos_next;
        pipe_in[0].busy     = (mode_next != MODE_IDLE);
        pipe_in[0].rejected = rejected;
        pipe_in[0].pos_mod  = posmod_next;
        pipe_in[0].target   = in_target;
        pipe_in[0].rem      = '0;
    end

    assign vin[0]   = s_acc;
    assign take[NS] = !o_valid_reg | m_tready;

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [WW-1:0]   shifted;
        logic [PW-1:0]   rem_new;
        hssp_pkg::pipe_t stage_next;

        if (k > 0) begin : g_link
            assign pipe_in[k] = pipe_reg[k-1];
            assign vin[k]     = v_reg[k-1];
        end

        assign take[k] = !v_reg[k] | take[k+1];

        always_comb begin
            shifted = {pipe_in[k].rem, pipe_in[k].target[NS-1-k]};
            if (shifted >= wrap) begin
                rem_new = PW'(shifted - wrap);
            end else begin
                rem_new = shifted[PW-1:0];
            end
            stage_next     = pipe_in[k];
            stage_next.rem = rem_new;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (take[k]) begin
                v_reg[k]    <= vin[k];
                pipe_reg[k] <= stage_next;
            end
        end
    end

    always_comb begin
        diff = {1'b0, pipe_reg[NS-1].rem} - {1'b0, pipe_reg[NS-1].pos_mod};
        if (pipe_reg[NS-1].rem < pipe_reg[NS-1].pos_mod) begin
            diff = diff + wrap;
        end
        fwd_dist = diff[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (take[NS]) begin
            o_valid_reg <= v_reg[NS-1];
            o_data_reg  <= {2'b00, pipe_reg[NS-1].rejected, fwd_dist, pipe_reg[NS-1].busy,
                            pipe_reg[NS-1].position, pipe_reg[NS-1].coils};
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        recalc_reg |-> !s_tready)
        else $error("item taken during position reduction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !recalc_reg |-> ({1'b0, posmod_reg} < wrap))
        else $error("reduced position not below wrap count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!recalc_reg && ({1'b0, pos_reg} < wrap)) |-> (posmod_reg == pos_reg))
        else $error("reduced position disagrees with position");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_kind == hssp_pkg::KIND_RELEASE)
            |=> (coil_reg == '0 && mode_reg == MODE_IDLE))
        else $error("release left coils driven or motion running");

endmodule

`default_nettype wire
